// ===== rtl/vvpu_pkg.sv =====
// ----------------------------------------------------------------------------
// Velocity Verlet update package
// Shared codes and fixed widths of the particle update block.
// ----------------------------------------------------------------------------
`default_nettype none

package vvpu_pkg;

   // fraction bits of every vector field
   localparam int FRAC_W = 32;
   // width of the time step register
   localparam int STEP_W = 32;

   typedef enum logic {
      FUNC_POS = 1'b0,
      FUNC_VEL = 1'b1
   } func_type;

endpackage

`default_nettype wire

// ===== rtl/vvpu_if.sv =====
// ----------------------------------------------------------------------------
// Velocity Verlet update channels
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface vvpu_req_if #(parameter int DATA_WIDTH = 48);
   logic                         valid;
   logic                         ready;
   vvpu_pkg::func_type           func;
   logic signed [DATA_WIDTH-1:0] first_x;
   logic signed [DATA_WIDTH-1:0] first_y;
   logic signed [DATA_WIDTH-1:0] first_z;
   logic signed [DATA_WIDTH-1:0] second_x;
   logic signed [DATA_WIDTH-1:0] second_y;
   logic signed [DATA_WIDTH-1:0] second_z;
   logic signed [DATA_WIDTH-1:0] third_x;
   logic signed [DATA_WIDTH-1:0] third_y;
   logic signed [DATA_WIDTH-1:0] third_z;
   logic        [DATA_WIDTH-2:0] mass;

   modport source (output valid, func, first_x, first_y, first_z, second_x, second_y,
                   second_z, third_x, third_y, third_z, mass, input ready);
   modport sink   (input valid, func, first_x, first_y, first_z, second_x, second_y,
                   second_z, third_x, third_y, third_z, mass, output ready);
endinterface

interface vvpu_rsp_if #(parameter int DATA_WIDTH = 48);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] out_x;
   logic signed [DATA_WIDTH-1:0] out_y;
   logic signed [DATA_WIDTH-1:0] out_z;
   logic signed [DATA_WIDTH-1:0] new_acc_x;
   logic signed [DATA_WIDTH-1:0] new_acc_y;
   logic signed [DATA_WIDTH-1:0] new_acc_z;
   logic                         div_zero;
   logic                         saturated;

   modport source (output valid, out_x, out_y, out_z, new_acc_x, new_acc_y, new_acc_z,
                   div_zero, saturated, input ready);
   modport sink   (input valid, out_x, out_y, out_z, new_acc_x, new_acc_y, new_acc_z,
                   div_zero, saturated, output ready);
endinterface

interface vvpu_csr_if;
   logic                          valid;
   logic                          ready;
   logic [vvpu_pkg::STEP_W-1:0]   data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/velocity_verlet_particle_update_top.sv =====
// ----------------------------------------------------------------------------
// Velocity Verlet particle update
// Pipelined position / velocity update of one particle vector per beat.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload
//  --------+-----+--------------------------------------------------------
//  req     | in  | func, first/second/third x,y,z, mass
//  rsp     | out | out x,y,z, new_acc x,y,z, div_zero, saturated
//  csr     | in  | data: time step dt, unsigned Q0.32
//
//  One beat per cycle enters and leaves while rsp does not stall; the
//  restoring divider resolves two quotient bits per stage. Reset
//  (synchronous) clears the valid bits and dt. A stall on rsp freezes
//  the whole pipe; req.ready drops in that cycle only when the output
//  register holds a beat, so nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module velocity_verlet_particle_update_top #(
   parameter int DATA_WIDTH = 48
) (
   input  wire      clock,
   input  wire      reset,
   vvpu_req_if.sink   req,
   vvpu_rsp_if.source rsp,
   vvpu_csr_if.sink   csr
);

   localparam int W   = DATA_WIDTH;
   localparam int FW  = vvpu_pkg::FRAC_W;
   localparam int TW  = vvpu_pkg::STEP_W;
   localparam int NW  = W + FW;              // dividend width
   localparam int SW  = W + 2;               // exact sum width before clipping
   localparam int SPL = W / 2;               // split of position multiplicand
   localparam int HW  = W - SPL;
   localparam int PW  = W + TW + 1;          // position product width
   localparam int SPV = (W + 1) / 2;         // split of velocity multiplicand
   localparam int HV  = W + 1 - SPV;
   localparam int PVW = W + TW + 2;          // velocity product width
   localparam int ND  = (W + 1) / 2;         // divider stages

   localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      vvpu_pkg::func_type func;
      logic [2:0][W-1:0]  keep;   // first field, or finished position
      logic [2:0][W-1:0]  acc;    // old acceleration
      logic [2:0]         cneg;
      logic [2:0]         ovf;
      logic [2:0][W-2:0]  rem;
      logic [2:0][W-1:0]  nlo;
      logic [2:0][W-1:0]  quo;
      logic [W-2:0]       m;
      logic               mz;
      logic               pclip;
   } dstage_type;

   // {clip, value}
   function automatic logic [W:0] sat_fn(input logic signed [SW-1:0] x);
      logic fits;
      fits = (&x[SW-1:W-1]) || ~(|x[SW-1:W-1]);
      if (fits) begin
         sat_fn = {1'b0, x[W-1:0]};
      end else begin
         sat_fn = {1'b1, (x[SW-1] ? MINV : MAXV)};
      end
   endfunction

   // {quotient bit, new remainder}
   function automatic logic [W-1:0] div_step(input logic [W-2:0] r, input logic nb,
                                             input logic [W-2:0] m);
      logic [W-1:0] t;
      logic [W-1:0] d;
      t = {r, nb};
      d = t - {1'b0, m};
      if (t >= {1'b0, m}) begin
         div_step = {1'b1, d[W-2:0]};
      end else begin
         div_step = {1'b0, t[W-2:0]};
      end
   endfunction

   // ---------------- configuration ----------------
   logic [TW-1:0] time_step_ff;
   logic [TW-1:0] hd2_ff;       // dt*dt/2, Q0.32
   logic [2*TW-1:0] dsq;

   assign csr.ready = 1'b1;
   assign dsq = (2*TW)'(csr.data) * (2*TW)'(csr.data) + ((2*TW)'(1) << FW);

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= '0;
         hd2_ff       <= '0;
      end else if (csr.valid) begin
         time_step_ff <= csr.data;
         hd2_ff       <= TW'(dsq >> (FW + 1));
      end
   end

   // ---------------- pipe enable ----------------
   logic vo_ff;
   logic en;
   assign en        = !vo_ff || rsp.ready;
   assign req.ready = en;

   // ---------------- stage 1: capture ----------------
   logic                  v1_ff;
   vvpu_pkg::func_type    f1_ff;
   logic signed [W-1:0]   a1_ff [0:2];
   logic signed [W-1:0]   b1_ff [0:2];
   logic signed [W-1:0]   c1_ff [0:2];
   logic [W-2:0]          m1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_ff    <= req.func;
         a1_ff[0] <= req.first_x;
         a1_ff[1] <= req.first_y;
         a1_ff[2] <= req.first_z;
         b1_ff[0] <= req.second_x;
         b1_ff[1] <= req.second_y;
         b1_ff[2] <= req.second_z;
         c1_ff[0] <= req.third_x;
         c1_ff[1] <= req.third_y;
         c1_ff[2] <= req.third_z;
         m1_ff    <= req.mass;
      end
   end

   // ---------------- stage 2: magnitudes, partial products ----------------
   dstage_type                s2_in, s2_ff;
   logic                      v2_ff;
   logic [SPL+TW-1:0]         pbl_in [0:2], pbl_ff [0:2];
   logic signed [HW+TW:0]     pbh_in [0:2], pbh_ff [0:2];
   logic [SPL+TW-1:0]         pcl_in [0:2], pcl_ff [0:2];
   logic signed [HW+TW:0]     pch_in [0:2], pch_ff [0:2];

   always_comb begin
      logic [W-1:0]  cmag;
      logic [NW-1:0] num;
      s2_in       = '0;
      s2_in.func  = f1_ff;
      s2_in.m     = m1_ff;
      s2_in.mz    = (m1_ff == '0);
      for (int l = 0; l < 3; l++) begin
         s2_in.keep[l] = a1_ff[l];
         s2_in.acc[l]  = b1_ff[l];
         s2_in.cneg[l] = c1_ff[l][W-1];
         cmag          = c1_ff[l][W-1] ? W'(-c1_ff[l]) : W'(c1_ff[l]);
         num           = {cmag, {FW{1'b0}}};
         // a quotient of 2^W or more clips whatever the low bits give
         s2_in.ovf[l]  = NW'(num[NW-1:W]) >= NW'(m1_ff);
         s2_in.rem[l]  = (W-1)'(num[NW-1:W]);
         s2_in.nlo[l]  = num[W-1:0];
         pbl_in[l]     = (SPL+TW)'(b1_ff[l][SPL-1:0]) * (SPL+TW)'(time_step_ff);
         pbh_in[l]     = $signed(b1_ff[l][W-1:SPL]) * $signed({1'b0, time_step_ff});
         pcl_in[l]     = (SPL+TW)'(c1_ff[l][SPL-1:0]) * (SPL+TW)'(hd2_ff);
         pch_in[l]     = $signed(c1_ff[l][W-1:SPL]) * $signed({1'b0, hd2_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff <= s2_in;
         for (int l = 0; l < 3; l++) begin
            pbl_ff[l] <= pbl_in[l];
            pbh_ff[l] <= pbh_in[l];
            pcl_ff[l] <= pcl_in[l];
            pch_ff[l] <= pch_in[l];
         end
      end
   end

   // ---------------- stage 3: finish position, enter divider ----------------
   dstage_type dv_ff  [0:ND];
   logic       dvv_ff [0:ND];
   dstage_type s3_in;

   always_comb begin
      logic signed [PW-1:0] pb, pc;
      logic signed [SW-1:0] sum;
      logic [W:0]           sr;
      s3_in = s2_ff;
      for (int l = 0; l < 3; l++) begin
         pb  = (PW'(pbh_ff[l]) <<< SPL) + $signed(PW'(pbl_ff[l]));
         pc  = (PW'(pch_ff[l]) <<< SPL) + $signed(PW'(pcl_ff[l]));
         // round half up to 32 fraction bits
         pb  = (pb + (PW'(1) <<< (FW - 1))) >>> FW;
         pc  = (pc + (PW'(1) <<< (FW - 1))) >>> FW;
         sum = SW'($signed(s2_ff.keep[l])) + SW'(pb) + SW'(pc);
         sr  = sat_fn(sum);
         s3_in.quo[l] = '0;
         if (s2_ff.func == vvpu_pkg::FUNC_POS) begin
            s3_in.keep[l] = sr[W-1:0];
            s3_in.pclip   = s3_in.pclip | sr[W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvv_ff[0] <= 1'b0;
      end else if (en) begin
         dvv_ff[0] <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[0] <= s3_in;
      end
   end

   // ---------------- divider: two quotient bits per stage ----------------
   for (genvar s = 1; s <= ND; s++) begin : g_div
      localparam bit TWO = (W - 2 * (s - 1)) >= 2;
      dstage_type nx;

      always_comb begin
         logic [W-1:0] st;
         nx = dv_ff[s-1];
         for (int l = 0; l < 3; l++) begin
            st         = div_step(nx.rem[l], nx.nlo[l][W-1], nx.m);
            nx.quo[l]  = {nx.quo[l][W-2:0], st[W-1]};
            nx.rem[l]  = st[W-2:0];
            nx.nlo[l]  = nx.nlo[l] << 1;
            if (TWO) begin
               st         = div_step(nx.rem[l], nx.nlo[l][W-1], nx.m);
               nx.quo[l]  = {nx.quo[l][W-2:0], st[W-1]};
               nx.rem[l]  = st[W-2:0];
               nx.nlo[l]  = nx.nlo[l] << 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dvv_ff[s] <= 1'b0;
         end else if (en) begin
            dvv_ff[s] <= dvv_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[s] <= nx;
         end
      end
   end

   // ---------------- back 1: clip quotient, sum accelerations ----------------
   logic                  vb1_ff;
   vvpu_pkg::func_type    fb1_ff;
   logic [2:0][W-1:0]     kb1_ff;
   logic [W-1:0]          na_in [0:2], nab1_ff [0:2];
   logic signed [W:0]     sa_in [0:2], sab1_ff [0:2];
   logic                  clb1_in, clb1_ff;
   logic                  dzb1_ff;

   always_comb begin
      dstage_type   d;
      logic         over;
      d       = dv_ff[ND];
      clb1_in = d.pclip;
      for (int l = 0; l < 3; l++) begin
         over = 1'b0;
         if (d.func == vvpu_pkg::FUNC_POS) begin
            na_in[l] = '0;
         end else if (d.mz) begin
            na_in[l] = d.cneg[l] ? MINV : MAXV;
         end else if (!d.cneg[l]) begin
            over     = d.ovf[l] | d.quo[l][W-1];
            na_in[l] = over ? MAXV : d.quo[l];
         end else begin
            over     = d.ovf[l] | (d.quo[l][W-1] & (|d.quo[l][W-2:0]));
            na_in[l] = over ? MINV : W'(-d.quo[l]);
         end
         clb1_in  = clb1_in | over;
         sa_in[l] = (W+1)'($signed(na_in[l])) + (W+1)'($signed(d.acc[l]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb1_ff <= 1'b0;
      end else if (en) begin
         vb1_ff <= dvv_ff[ND];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fb1_ff  <= dv_ff[ND].func;
         kb1_ff  <= dv_ff[ND].keep;
         clb1_ff <= clb1_in;
         dzb1_ff <= (dv_ff[ND].func == vvpu_pkg::FUNC_VEL) && dv_ff[ND].mz;
         for (int l = 0; l < 3; l++) begin
            nab1_ff[l] <= na_in[l];
            sab1_ff[l] <= sa_in[l];
         end
      end
   end

   // ---------------- back 2: partial products of (a_old + a_new) * dt ----------------
   logic                  vb2_ff;
   vvpu_pkg::func_type    fb2_ff;
   logic [2:0][W-1:0]     kb2_ff;
   logic [W-1:0]          nab2_ff [0:2];
   logic [SPV+TW-1:0]     pvl_ff [0:2];
   logic signed [HV+TW:0] pvh_ff [0:2];
   logic                  clb2_ff;
   logic                  dzb2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb2_ff <= 1'b0;
      end else if (en) begin
         vb2_ff <= vb1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fb2_ff  <= fb1_ff;
         kb2_ff  <= kb1_ff;
         clb2_ff <= clb1_ff;
         dzb2_ff <= dzb1_ff;
         for (int l = 0; l < 3; l++) begin
            nab2_ff[l] <= nab1_ff[l];
            pvl_ff[l]  <= (SPV+TW)'(sab1_ff[l][SPV-1:0]) * (SPV+TW)'(time_step_ff);
            pvh_ff[l]  <= $signed(sab1_ff[l][W:SPV]) * $signed({1'b0, time_step_ff});
         end
      end
   end

   // ---------------- back 3: round, add, clip into output register ----------------
   logic [W-1:0] ox_in [0:2], ox_ff [0:2];
   logic [W-1:0] na_ff [0:2];
   logic         sat_in, sat_ff;
   logic         dz_ff;

   always_comb begin
      logic signed [PVW-1:0] p;
      logic signed [SW-1:0]  sum;
      logic [W:0]            sr;
      sat_in = clb2_ff;
      for (int l = 0; l < 3; l++) begin
         p   = (PVW'(pvh_ff[l]) <<< SPV) + $signed(PVW'(pvl_ff[l]));
         // halve dt and round in one go
         p   = (p + (PVW'(1) <<< FW)) >>> (FW + 1);
         sum = SW'($signed(kb2_ff[l])) + SW'(p);
         sr  = sat_fn(sum);
         if (fb2_ff == vvpu_pkg::FUNC_POS) begin
            ox_in[l] = kb2_ff[l];
         end else begin
            ox_in[l] = sr[W-1:0];
            sat_in   = sat_in | sr[W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= vb2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sat_ff <= sat_in;
         dz_ff  <= dzb2_ff;
         for (int l = 0; l < 3; l++) begin
            ox_ff[l] <= ox_in[l];
            na_ff[l] <= nab2_ff[l];
         end
      end
   end

   assign rsp.valid     = vo_ff;
   assign rsp.out_x     = ox_ff[0];
   assign rsp.out_y     = ox_ff[1];
   assign rsp.out_z     = ox_ff[2];
   assign rsp.new_acc_x = na_ff[0];
   assign rsp.new_acc_y = na_ff[1];
   assign rsp.new_acc_z = na_ff[2];
   assign rsp.div_zero  = dz_ff;
   assign rsp.saturated = sat_ff;

endmodule

`default_nettype wire
